[rtl/lidar_point_false_color_top_defines.svh]
// Assertion helpers used by lpfc_back.
`ifndef LIDAR_POINT_FALSE_COLOR_TOP_DEFINES_SVH
`define LIDAR_POINT_FALSE_COLOR_TOP_DEFINES_SVH

`define LPFC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

`define LPFC_ASSERT_NEXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");

`endif

[rtl/lpfc_pkg.sv]
`default_nettype none
package lpfc_pkg;

  typedef enum logic [1:0] {
    MODE_POLY      = 2'd0,
    MODE_CAMERA    = 2'd1,
    MODE_INTENSITY = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam logic [21:0] CYCLE_RESET = 22'd65000;
  localparam logic [21:0] CYCLE_MIN   = 22'd6;
  localparam logic [21:0] LEVEL_SEG   = 22'd42;
  // ceil(2^25 / 6); exact division by six for any 22-bit value.
  localparam logic [22:0] SIXTH_MUL   = 23'd5592406;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic [31:0]        flight_time;
    logic [7:0]         echo_level;
    logic [7:0]         cam_red;
    logic [7:0]         cam_green;
    logic [7:0]         cam_blue;
    logic [31:0]        stamp_sec;
    logic [19:0]        stamp_usec;
  } point_t;

  typedef struct packed {
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic signed [19:0] out_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         out_level;
    logic [31:0]        out_sec;
    logic [19:0]        out_usec;
  } color_t;

  typedef struct packed {
    mode_t       mode;
    logic [21:0] cyc;
    point_t      pt;
  } work_t;

  function automatic logic [23:0] edge_color(input logic [2:0] k);
    logic [23:0] c;
    case (k)
      3'd0: c = 24'hffff00;
      3'd1: c = 24'hff0000;
      3'd2: c = 24'hff00ff;
      3'd3: c = 24'h0000ff;
      3'd4: c = 24'h00ffff;
      3'd5: c = 24'h00ff00;
      default: c = 24'hffff00;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] blend(input logic [2:0] cls, input logic [7:0] step);
    logic [2:0]  k;
    logic [2:0]  kn;
    logic [23:0] base;
    logic [23:0] nxt;
    logic [23:0] diff;
    logic [23:0] delta;
    k = (cls >= 3'd6) ? 3'd0 : cls;
    kn = (k == 3'd5) ? 3'd0 : k + 3'd1;
    base = edge_color(k);
    nxt = edge_color(kn);
    diff = base ^ nxt;
    if (diff[7:0] != 8'd0) begin
      delta = {16'd0, step};
    end else if (diff[15:8] != 8'd0) begin
      delta = {8'd0, step, 8'd0};
    end else begin
      delta = {step, 16'd0};
    end
    return (nxt > base) ? base + delta : base - delta;
  endfunction

endpackage
`default_nettype wire

[rtl/lpfc_fifo.sv]
`default_nettype none
module lpfc_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire T     wdata,
  output logic      full,
  input  wire logic rd,
  output T          rdata,
  output logic      empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/lpfc_front.sv]
`default_nettype none
module lpfc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_index,
  input  wire logic [21:0]     cfg_data,
  input  wire logic            push,
  input  wire lpfc_pkg::point_t point,
  output logic                 full,
  output logic                 work_valid,
  output lpfc_pkg::work_t      work,
  input  wire logic            work_full
);
  lpfc_pkg::mode_t mode;
  logic [21:0] cycle;
  logic ready;

  assign ready = !work_valid || !work_full;
  assign full = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lpfc_pkg::MODE_POLY;
      cycle <= lpfc_pkg::CYCLE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lpfc_pkg::REG_MODE: mode <= lpfc_pkg::mode_t'(cfg_data[1:0]);
        lpfc_pkg::REG_PERIOD: cycle <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (push && ready) begin
      work_valid <= (point.pos_z != 20'sd0);
    end else if (!work_full) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ready) begin
      work.mode <= mode;
      work.cyc <= (cycle < lpfc_pkg::CYCLE_MIN) ? lpfc_pkg::CYCLE_MIN : cycle;
      work.pt <= point;
    end
  end
endmodule
`default_nettype wire

[rtl/lpfc_back.sv]
`default_nettype none
`include "lidar_point_false_color_top_defines.svh"
module lpfc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            work_empty,
  input  wire lpfc_pkg::work_t work,
  output logic                 work_pop,
  output logic                 res_push,
  output lpfc_pkg::color_t     res,
  input  wire logic            res_full
);
  localparam int MS = 32;
  localparam int QS = 8;

  logic en;

  logic            mv [MS];
  lpfc_pkg::work_t mw [MS];
  logic [22:0]     mr [MS];
  logic [22:0]     mr_next [MS];

  logic            sv;
  lpfc_pkg::work_t sw;
  logic [21:0]     s_seg;
  logic [21:0]     s_v;
  logic [45:0]     prod;

  logic            cv;
  lpfc_pkg::work_t cw;
  logic [21:0]     c_seg;
  logic [21:0]     c_v;
  logic [24:0]     c_mul [1:10];

  logic            dv;
  lpfc_pkg::work_t dw;
  logic [21:0]     d_seg;
  logic [2:0]      d_cls;
  logic [21:0]     d_rest;
  logic [3:0]      cls_c;
  logic [24:0]     sub_c;

  logic            qv [QS];
  lpfc_pkg::work_t qw [QS];
  logic [21:0]     qseg [QS];
  logic [2:0]      qcls [QS];
  logic [22:0]     qr [QS];
  logic [7:0]      qq [QS];
  logic [22:0]     qr_next [QS];
  logic [7:0]      qq_next [QS];

  logic            fv;
  logic [23:0]     rgb;

  assign en = !fv || !res_full;
  assign work_pop = en && !work_empty;
  assign res_push = fv;

  always_comb begin
    logic [22:0] t;
    for (int i = 0; i < MS; i++) begin
      if (i == 0) begin
        t = {22'd0, work.pt.flight_time[MS-1]};
        mr_next[i] = (t >= {1'b0, work.cyc}) ? t - {1'b0, work.cyc} : t;
      end else begin
        t = {mr[i-1][21:0], mw[i-1].pt.flight_time[MS-1-i]};
        mr_next[i] = (t >= {1'b0, mw[i-1].cyc}) ? t - {1'b0, mw[i-1].cyc} : t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MS; i++) begin
        mv[i] <= 1'b0;
      end
    end else if (en) begin
      mv[0] <= !work_empty;
      for (int i = 1; i < MS; i++) begin
        mv[i] <= mv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mw[0] <= work;
      mr[0] <= mr_next[0];
      for (int i = 1; i < MS; i++) begin
        mw[i] <= mw[i-1];
        mr[i] <= mr_next[i];
      end
    end
  end

  assign prod = {24'd0, mw[MS-1].cyc} * {23'd0, lpfc_pkg::SIXTH_MUL};

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
      cv <= 1'b0;
      dv <= 1'b0;
    end else if (en) begin
      sv <= mv[MS-1];
      cv <= sv;
      dv <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sw <= mw[MS-1];
      if (mw[MS-1].mode == lpfc_pkg::MODE_POLY) begin
        s_seg <= {1'b0, prod[45:25]};
        s_v <= mr[MS-1][21:0];
      end else begin
        s_seg <= lpfc_pkg::LEVEL_SEG;
        s_v <= {14'd0, mw[MS-1].pt.echo_level};
      end
      cw <= sw;
      c_seg <= s_seg;
      c_v <= s_v;
      c_mul[1] <= {3'd0, s_seg};
      c_mul[2] <= {2'd0, s_seg, 1'b0};
      c_mul[3] <= {2'd0, s_seg, 1'b0} + {3'd0, s_seg};
      c_mul[4] <= {1'd0, s_seg, 2'b0};
      c_mul[5] <= {1'd0, s_seg, 2'b0} + {3'd0, s_seg};
      c_mul[6] <= {1'd0, s_seg, 2'b0} + {2'd0, s_seg, 1'b0};
      c_mul[7] <= {1'd0, s_seg, 2'b0} + {2'd0, s_seg, 1'b0} + {3'd0, s_seg};
      c_mul[8] <= {s_seg, 3'b0};
      c_mul[9] <= {s_seg, 3'b0} + {3'd0, s_seg};
      c_mul[10] <= {s_seg, 3'b0} + {2'd0, s_seg, 1'b0};
      dw <= cw;
      d_seg <= c_seg;
      d_cls <= (cls_c >= 4'd6) ? 3'(cls_c - 4'd6) : cls_c[2:0];
      d_rest <= 22'(c_v - sub_c);
    end
  end

  // A short tof period leaves room for up to ten whole segments; the class wraps
  // around the six-color ring.
  always_comb begin
    cls_c = 4'd0;
    sub_c = 25'd0;
    for (int k = 1; k <= 10; k++) begin
      if (c_mul[k] <= {3'd0, c_v}) begin
        cls_c = 4'(k);
        sub_c = c_mul[k];
      end
    end
  end

  always_comb begin
    logic [22:0] t;
    logic [21:0] sg;
    for (int i = 0; i < QS; i++) begin
      if (i == 0) begin
        t = {d_rest, 1'b0};
        sg = d_seg;
        qq_next[i] = 8'd0;
      end else begin
        t = {qr[i-1][21:0], 1'b0};
        sg = qseg[i-1];
        qq_next[i] = qq[i-1];
      end
      if (t >= {1'b0, sg}) begin
        qr_next[i] = t - {1'b0, sg};
        qq_next[i] = {qq_next[i][6:0], 1'b1};
      end else begin
        qr_next[i] = t;
        qq_next[i] = {qq_next[i][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QS; i++) begin
        qv[i] <= 1'b0;
      end
      fv <= 1'b0;
    end else if (en) begin
      qv[0] <= dv;
      for (int i = 1; i < QS; i++) begin
        qv[i] <= qv[i-1];
      end
      fv <= qv[QS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw[0] <= dw;
      qseg[0] <= d_seg;
      qcls[0] <= d_cls;
      qr[0] <= qr_next[0];
      qq[0] <= qq_next[0];
      for (int i = 1; i < QS; i++) begin
        qw[i] <= qw[i-1];
        qseg[i] <= qseg[i-1];
        qcls[i] <= qcls[i-1];
        qr[i] <= qr_next[i];
        qq[i] <= qq_next[i];
      end
    end
  end

  always_comb begin
    case (qw[QS-1].mode)
      lpfc_pkg::MODE_POLY: rgb = lpfc_pkg::blend(qcls[QS-1], qq[QS-1]);
      lpfc_pkg::MODE_INTENSITY: rgb = lpfc_pkg::blend(qcls[QS-1], qq[QS-1]);
      lpfc_pkg::MODE_CAMERA: rgb = {qw[QS-1].pt.cam_red, qw[QS-1].pt.cam_green,
                                    qw[QS-1].pt.cam_blue};
      default: rgb = 24'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x <= qw[QS-1].pt.pos_x;
      res.out_y <= qw[QS-1].pt.pos_y;
      res.out_z <= qw[QS-1].pt.pos_z;
      res.red <= rgb[23:16];
      res.green <= rgb[15:8];
      res.blue <= rgb[7:0];
      res.out_level <= qw[QS-1].pt.echo_level;
      res.out_sec <= qw[QS-1].pt.stamp_sec;
      res.out_usec <= qw[QS-1].pt.stamp_usec;
    end
  end

  `LPFC_ASSERT_NEVER(a_class_range, dv && (d_cls > 3'd5))
  `LPFC_ASSERT_NEVER(a_rest_below_seg, dv && (d_rest >= d_seg))
  `LPFC_ASSERT_NEXT(a_stall_holds, fv && res_full, fv && $stable(res))
endmodule
`default_nettype wire

[rtl/lidar_point_false_color_top.sv]
// Throughput: one point per cycle unless a full queue stalls the flow; the
// 32-stage tof remainder pipeline, the class stages and the 8-stage blend
// divider each take one point per cycle.
// Points with zero z are dropped in the front stage and give no transaction.
// Reset (rst, synchronous, active high) empties all queues and stages and
// sets the color mode to polychrome and the tof period to 65000.
`default_nettype none
module lidar_point_false_color_top #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [21:0]      cfg_data,
  input  wire logic             push,
  input  wire lpfc_pkg::point_t point,
  output logic                  full,
  input  wire logic             pop,
  output lpfc_pkg::color_t      colored,
  output logic                  empty
);
  logic            fw_valid;
  lpfc_pkg::work_t fw;
  logic            mid_full;
  logic            mid_empty;
  logic            mid_pop;
  lpfc_pkg::work_t mid_head;
  logic            res_push;
  lpfc_pkg::color_t res;
  logic            res_full;

  lpfc_front u_front (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .point(point), .full(full),
    .work_valid(fw_valid), .work(fw), .work_full(mid_full)
  );

  lpfc_fifo #(.T(lpfc_pkg::work_t), .DEPTH(MID_DEPTH)) u_mid (
    .clk(clk), .rst(rst),
    .wr(fw_valid), .wdata(fw), .full(mid_full),
    .rd(mid_pop), .rdata(mid_head), .empty(mid_empty)
  );

  lpfc_back u_back (
    .clk(clk), .rst(rst),
    .work_empty(mid_empty), .work(mid_head), .work_pop(mid_pop),
    .res_push(res_push), .res(res), .res_full(res_full)
  );

  lpfc_fifo #(.T(lpfc_pkg::color_t), .DEPTH(OUT_DEPTH)) u_out (
    .clk(clk), .rst(rst),
    .wr(res_push), .wdata(res), .full(res_full),
    .rd(pop), .rdata(colored), .empty(empty)
  );
endmodule
`default_nettype wire
